/* rtl/pid_filtered_derivative_antiwindup_assert.svh */
// Assertion macros used by the top level of the PID controller.
`ifndef PID_FILTERED_DERIVATIVE_ANTIWINDUP_ASSERT_SVH
`define PID_FILTERED_DERIVATIVE_ANTIWINDUP_ASSERT_SVH

// Same-cycle implication, clocked on clk and disabled while arst_n is low.
`define PFDAW_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pfdaw assertion failed");

// Next-cycle implication, clocked on clk and disabled while arst_n is low.
`define PFDAW_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pfdaw assertion failed");

`endif

/* rtl/pfdaw_pkg.sv */
// Shared types, widths and helper functions for the PID controller.
package pfdaw_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int DATA_W        = 32;
	localparam int STATE_W       = 48;
	localparam int LIMIT_W       = 31;
	localparam int POLE_W        = 18;
	localparam int CFG_IDX_W     = 3;
	// Multiplier operands: A covers a 49-bit difference, B a 32-bit signed gain.
	localparam int OPA_W         = 50;
	localparam int OPB_W         = 33;
	localparam int SPLIT_W       = 25;
	localparam int PLO_W         = SPLIT_W + 1 + OPB_W;
	localparam int PHI_W         = OPA_W - SPLIT_W + OPB_W;
	localparam int PROD_W        = OPA_W + OPB_W;

	typedef enum logic [2:0] {
		REG_PROP_GAIN,
		REG_INTEG_GAIN,
		REG_DIFF_GAIN,
		REG_OUT_LIMIT,
		REG_HALF_PERIOD,
		REG_DERIV_POLE,
		REG_DERIV_SCALE,
		REG_WINDUP_GAIN
	} reg_idx_t;

	typedef enum logic [2:0] {
		OP_INTEG,
		OP_POLE,
		OP_SCALE,
		OP_PROP,
		OP_INTGAIN,
		OP_DIFF,
		OP_WINDUP
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OPERAND,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_COMBINE,
		ST_UPDATE,
		ST_DELIVER
	} state_t;

	typedef struct packed {
		logic signed [DATA_W-1:0]  prop_gain;
		logic signed [DATA_W-1:0]  integ_gain;
		logic signed [DATA_W-1:0]  diff_gain;
		logic        [LIMIT_W-1:0] out_limit;
		logic        [LIMIT_W-1:0] half_period;
		logic signed [POLE_W-1:0]  deriv_pole;
		logic        [LIMIT_W-1:0] deriv_scale;
		logic signed [DATA_W-1:0]  windup_gain;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic operand;
		logic mul_lo;
		logic mul_hi;
		logic combine;
		logic update;
		logic deliver;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic windup_en;
	} sts_t;

	// Saturate a wide signed sum to the 48-bit state range.
	function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [OPA_W-1:0] v);
		logic signed [STATE_W-1:0] r;
		if (v[OPA_W-1:STATE_W-1] == {(OPA_W-STATE_W+1){v[OPA_W-1]}}) begin
			r = v[STATE_W-1:0];
		end else if (v[OPA_W-1]) begin
			r = {1'b1, {(STATE_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(STATE_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

/* rtl/pfdaw_cfg.sv */
// Configuration register bank of the PID controller.
module pfdaw_cfg import pfdaw_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	// The bank can always take a write beat.
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Register writes, each field truncated to its own width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_PROP_GAIN:   cfg_q.prop_gain   <= cfg_data;
				REG_INTEG_GAIN:  cfg_q.integ_gain  <= cfg_data;
				REG_DIFF_GAIN:   cfg_q.diff_gain   <= cfg_data;
				REG_OUT_LIMIT:   cfg_q.out_limit   <= cfg_data[LIMIT_W-1:0];
				REG_HALF_PERIOD: cfg_q.half_period <= cfg_data[LIMIT_W-1:0];
				REG_DERIV_POLE:  cfg_q.deriv_pole  <= cfg_data[POLE_W-1:0];
				REG_DERIV_SCALE: cfg_q.deriv_scale <= cfg_data[LIMIT_W-1:0];
				REG_WINDUP_GAIN: cfg_q.windup_gain <= cfg_data;
			endcase
		end
	end

endmodule

/* rtl/pfdaw_dp.sv */
// Datapath of the PID controller: state, shared multiplier and output register.
module pfdaw_dp import pfdaw_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  cmd_t                     cmd,
	input  logic signed [DATA_W-1:0] setpoint,
	input  logic signed [DATA_W-1:0] measurement,
	input  logic                     clear_state,
	output sts_t                     sts,
	output logic [DATA_W-1:0]        drive
);

	logic signed [DATA_W-1:0]  err_q;
	logic signed [DATA_W-1:0]  prev_q;
	logic signed [STATE_W-1:0] integ_q;
	logic signed [STATE_W-1:0] fd_q;
	logic signed [STATE_W-1:0] raw_q;
	logic signed [OPA_W-1:0]   acc_q;
	logic signed [OPA_W-1:0]   opa_q;
	logic signed [OPB_W-1:0]   opb_q;
	logic signed [PLO_W-1:0]   plo_q;
	logic signed [PHI_W-1:0]   phi_q;
	logic signed [STATE_W-1:0] prod_q;
	logic        [DATA_W-1:0]  drive_q;

	logic signed [DATA_W:0]    diff_c;
	logic signed [DATA_W-1:0]  err_c;
	logic signed [STATE_W-1:0] lim_c;
	logic signed [STATE_W-1:0] drive_c;
	logic signed [OPA_W-1:0]   opa_c;
	logic signed [OPB_W-1:0]   opb_c;
	logic signed [SPLIT_W:0]   mul_a_c;
	logic signed [PLO_W-1:0]   mul_c;
	logic signed [PROD_W-1:0]  full_c;
	logic signed [PROD_W-1:0]  shr_c;
	logic signed [STATE_W-1:0] prod_c;
	logic signed [OPA_W-1:0]   sum_int_c;
	logic signed [OPA_W-1:0]   sum_acc_c;

	assign sts.windup_en = (cfg.integ_gain != '0);
	assign drive         = drive_q;

	// Control error, saturated to 32 bits.
	assign diff_c = (DATA_W+1)'(setpoint) - (DATA_W+1)'(measurement);
	always_comb begin
		if (diff_c[DATA_W] == diff_c[DATA_W-1]) begin
			err_c = diff_c[DATA_W-1:0];
		end else if (diff_c[DATA_W]) begin
			err_c = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			err_c = {1'b0, {(DATA_W-1){1'b1}}};
		end
	end

	// Output clamp to plus or minus the limit.
	assign lim_c = STATE_W'(cfg.out_limit);
	always_comb begin
		if (raw_q > lim_c) begin
			drive_c = lim_c;
		end else if (raw_q < -lim_c) begin
			drive_c = -lim_c;
		end else begin
			drive_c = raw_q;
		end
	end

	// Operand selection for the current product.
	always_comb begin
		unique case (cmd.op)
			OP_INTEG: begin
				opa_c = OPA_W'(err_q) + OPA_W'(prev_q);
				opb_c = OPB_W'(cfg.half_period);
			end
			OP_POLE: begin
				opa_c = OPA_W'(fd_q);
				opb_c = OPB_W'(cfg.deriv_pole);
			end
			OP_SCALE: begin
				opa_c = OPA_W'(err_q) - OPA_W'(prev_q);
				opb_c = OPB_W'(cfg.deriv_scale);
			end
			OP_PROP: begin
				opa_c = OPA_W'(err_q);
				opb_c = OPB_W'(cfg.prop_gain);
			end
			OP_INTGAIN: begin
				opa_c = OPA_W'(integ_q);
				opb_c = OPB_W'(cfg.integ_gain);
			end
			OP_DIFF: begin
				opa_c = OPA_W'(fd_q);
				opb_c = OPB_W'(cfg.diff_gain);
			end
			OP_WINDUP: begin
				opa_c = OPA_W'(drive_c) - OPA_W'(raw_q);
				opb_c = OPB_W'(cfg.windup_gain);
			end
			default: begin
				opa_c = '0;
				opb_c = '0;
			end
		endcase
	end

	// One multiplier, two passes over the split A operand: low part unsigned,
	// high part signed.
	assign mul_a_c = cmd.mul_hi ? $signed({opa_q[OPA_W-1], opa_q[OPA_W-1:SPLIT_W]})
		: $signed({1'b0, opa_q[SPLIT_W-1:0]});
	assign mul_c   = mul_a_c * opb_q;

	// Exact product, floor shift by the fraction bits, saturate to 48 bits.
	assign full_c = (PROD_W'(phi_q) <<< SPLIT_W) + PROD_W'(plo_q);
	assign shr_c  = full_c >>> FRAC_BITS;
	always_comb begin
		if (shr_c[PROD_W-1:STATE_W-1] == {(PROD_W-STATE_W+1){shr_c[PROD_W-1]}}) begin
			prod_c = shr_c[STATE_W-1:0];
		end else if (shr_c[PROD_W-1]) begin
			prod_c = {1'b1, {(STATE_W-1){1'b0}}};
		end else begin
			prod_c = {1'b0, {(STATE_W-1){1'b1}}};
		end
	end

	assign sum_int_c = OPA_W'(integ_q) + OPA_W'(prod_q);
	assign sum_acc_c = acc_q + OPA_W'(prod_q);

	// Controller state: cleared on request, updated as each product lands.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			fd_q    <= '0;
			prev_q  <= '0;
		end else if (cmd.load) begin
			if (clear_state) begin
				integ_q <= '0;
				fd_q    <= '0;
				prev_q  <= '0;
			end
		end else if (cmd.update) begin
			unique case (cmd.op)
				OP_INTEG, OP_WINDUP: integ_q <= sat_state(sum_int_c);
				OP_SCALE: begin
					fd_q   <= sat_state(sum_acc_c);
					prev_q <= err_q;
				end
				default: ;
			endcase
		end
	end

	// Working registers of the multiply sequence.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			err_q <= err_c;
		end
		if (cmd.operand) begin
			opa_q <= opa_c;
			opb_q <= opb_c;
		end
		if (cmd.mul_lo) begin
			plo_q <= mul_c;
		end
		if (cmd.mul_hi) begin
			phi_q <= mul_c[PHI_W-1:0];
		end
		if (cmd.combine) begin
			prod_q <= prod_c;
		end
		if (cmd.update) begin
			unique case (cmd.op)
				OP_POLE, OP_PROP: acc_q <= OPA_W'(prod_q);
				OP_INTGAIN:       acc_q <= sum_acc_c;
				OP_DIFF:          raw_q <= sat_state(sum_acc_c);
				default: ;
			endcase
		end
		if (cmd.deliver) begin
			drive_q <= drive_c[DATA_W-1:0];
		end
	end

endmodule

/* rtl/pfdaw_ctrl.sv */
// Sequencing state machine of the PID controller.
module pfdaw_ctrl import pfdaw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	output logic m_tvalid,
	input  logic m_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;
	op_t    op_q, op_d;
	logic   out_valid_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	// State, product index and output beat flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_INTEG;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			if (cmd.deliver) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and datapath commands; each product takes five steps.
	always_comb begin
		state_d     = state_q;
		op_d        = op_q;
		cmd         = '0;
		cmd.op      = op_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					op_d     = OP_INTEG;
					state_d  = ST_OPERAND;
				end
			end
			ST_OPERAND: begin
				cmd.operand = 1'b1;
				state_d     = ST_MUL_LO;
			end
			ST_MUL_LO: begin
				cmd.mul_lo = 1'b1;
				state_d    = ST_MUL_HI;
			end
			ST_MUL_HI: begin
				cmd.mul_hi = 1'b1;
				state_d    = ST_COMBINE;
			end
			ST_COMBINE: begin
				cmd.combine = 1'b1;
				state_d     = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = ST_OPERAND;
				unique case (op_q)
					OP_INTEG:   op_d = OP_POLE;
					OP_POLE:    op_d = OP_SCALE;
					OP_SCALE:   op_d = OP_PROP;
					OP_PROP:    op_d = OP_INTGAIN;
					OP_INTGAIN: op_d = OP_DIFF;
					OP_DIFF: begin
						if (sts.windup_en) begin
							op_d = OP_WINDUP;
						end else begin
							state_d = ST_DELIVER;
						end
					end
					default: state_d = ST_DELIVER;
				endcase
			end
			ST_DELIVER: begin
				if (!out_valid_q || m_tready) begin
					cmd.deliver = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

/* rtl/pid_filtered_derivative_antiwindup.sv */
// Top level of the discrete PID controller with filtered derivative and anti-windup.
// Each input beat carries a setpoint and a measurement (Q16.16) and a clear flag in
// tuser; one drive beat comes out per input. The block works on one sample at a time:
// all products go through one shared 26x33-bit multiplier, two passes per product plus
// operand, combine and update steps. A sample needs six products with zero integral
// gain and seven with anti-windup correction active. A finished drive beat waits in
// an output register, so the next sample is taken while the previous result is unread.
// Configuration is written through the cfg port only while no sample is in flight;
// the user must keep to this, as the block itself does not enforce it.
`include "pid_filtered_derivative_antiwindup_assert.svh"

module pid_filtered_derivative_antiwindup import pfdaw_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [2*DATA_W-1:0]  s_tdata,    // setpoint [31:0], measurement [63:32]
	input  logic                 s_tuser,    // clear_state
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [DATA_W-1:0]    m_tdata,    // drive [31:0]
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data
);

	cfg_t       cfg;
	cmd_t       cmd;
	sts_t       sts;
	logic [6:0] step_vec;

	pfdaw_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pfdaw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pfdaw_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.setpoint    (s_tdata[DATA_W-1:0]),
		.measurement (s_tdata[2*DATA_W-1:DATA_W]),
		.clear_state (s_tuser),
		.sts         (sts),
		.drive       (m_tdata)
	);

	// Datapath step strobes gathered for the one-step check.
	assign step_vec = {cmd.load, cmd.operand, cmd.mul_lo, cmd.mul_hi, cmd.combine,
		cmd.update, cmd.deliver};

	// An accepted sample keeps the input side closed on the following cycle.
	`PFDAW_ASSERT_NEXT(a_busy_after_load, cmd.load, !s_tready)
	// A delivered result is presented on the output on the following cycle.
	`PFDAW_ASSERT_NEXT(a_valid_after_deliver, cmd.deliver, m_tvalid)
	// The sequencer issues at most one datapath step per cycle.
	`PFDAW_ASSERT_IMP(a_one_step, 1'b1, $onehot0(step_vec))
	// The back-calculation product only runs with a nonzero integral gain.
	`PFDAW_ASSERT_IMP(a_windup_gated, cmd.update && (cmd.op == OP_WINDUP), sts.windup_en)

endmodule
